### src/pls_pkg.sv
package pls_pkg;

  localparam int OP_BITS = 3;

  typedef enum logic [OP_BITS-1:0] {
    OP_APPEND      = 3'd0,
    OP_INSERT      = 3'd1,
    OP_DELETE_AT   = 3'd2,
    OP_DELETE_LAST = 3'd3,
    OP_READ        = 3'd4
  } op_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

### src/pls_cell.sv
module pls_cell #(
  parameter int IDX       = 0,
  parameter int CW        = 7,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  pls_pkg::cell_cmd_t   cmd,
  input  logic [CW-1:0]        pos,
  input  logic [WORD_BITS-1:0] word_in,
  input  logic [WORD_BITS-1:0] lower_in,
  input  logic [WORD_BITS-1:0] upper_in,
  output logic [WORD_BITS-1:0] word_out,
  output logic [WORD_BITS-1:0] rd_out
);
  import pls_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (IDX_C > pos) begin
        word_nxt = lower_in;
      end else if (IDX_C == pos) begin
        word_nxt = word_in;
      end
    end else if (cmd.del) begin
      if (IDX_C >= pos) begin
        word_nxt = upper_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_out = word_r;
  assign rd_out   = (IDX_C == pos) ? word_r : '0;

endmodule

### src/positional_list_store_unit.sv
// a result is registered and appears in the cycle after its request transaction is taken
// throughput: one request per cycle while in_stall is low; every cell shifts, loads or holds in that cycle
// a waiting result does not block the next transaction unless out_stall is high
// reset: synchronous active-low rst_n empties the list and clears out_valid
// stored words keep their contents through reset and are read only after written
module positional_list_store_unit #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pls_pkg::OP_BITS-1:0]  in_operation,
  input  logic [CW-1:0]                in_position,
  input  logic [WORD_BITS-1:0]         in_element_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_accepted,
  output logic [WORD_BITS-1:0]         out_read_word,
  output logic [CW-1:0]                out_entry_count,
  output logic                         out_is_vacant,
  output logic                         out_is_full
);
  import pls_pkg::*;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]        len_r, len_nxt;
  logic                 out_valid_r;
  logic                 accepted_r;
  logic [WORD_BITS-1:0] read_word_r;
  logic [CW-1:0]        count_r;
  logic                 vacant_r, full_r;

  logic                 take;
  logic                 ok;
  logic                 is_read;
  logic [CW-1:0]        cell_pos;
  cell_cmd_t            cmd;
  logic [WORD_BITS-1:0] rd_sum;

  logic [WORD_BITS-1:0] cell_q  [CAPACITY];
  logic [WORD_BITS-1:0] cell_rd [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    ok       = 1'b0;
    is_read  = 1'b0;
    cmd      = '0;
    cell_pos = in_position;
    len_nxt  = len_r;
    unique case (in_operation)
      OP_APPEND: begin
        cell_pos = len_r;
        if (len_r != CAP_C) begin
          ok      = 1'b1;
          cmd.ins = 1'b1;
          len_nxt = len_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (len_r != CAP_C && in_position <= len_r) begin
          ok      = 1'b1;
          cmd.ins = 1'b1;
          len_nxt = len_r + 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (in_position < len_r) begin
          ok      = 1'b1;
          cmd.del = 1'b1;
          len_nxt = len_r - 1'b1;
        end
      end
      OP_DELETE_LAST: begin
        if (len_r != '0) begin
          ok      = 1'b1;
          len_nxt = len_r - 1'b1;
        end
      end
      OP_READ: begin
        if (in_position < len_r) begin
          ok      = 1'b1;
          is_read = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!take) begin
      cmd     = '0;
      len_nxt = len_r;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] lower_w, upper_w;
    if (g == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_mid_lo
      assign lower_w = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper_w = cell_q[g];
    end else begin : g_mid_hi
      assign upper_w = cell_q[g+1];
    end
    pls_cell #(
      .IDX       (g),
      .CW        (CW),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (cell_pos),
      .word_in  (in_element_value),
      .lower_in (lower_w),
      .upper_in (upper_w),
      .word_out (cell_q[g]),
      .rd_out   (cell_rd[g])
    );
  end

  always_comb begin
    rd_sum = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sum = rd_sum | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted_r  <= ok;
      read_word_r <= is_read ? rd_sum : '0;
      count_r     <= len_nxt;
      vacant_r    <= (len_nxt == '0);
      full_r      <= (len_nxt == CAP_C);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = accepted_r;
  assign out_read_word   = read_word_r;
  assign out_entry_count = count_r;
  assign out_is_vacant   = vacant_r;
  assign out_is_full     = full_r;

endmodule

### dv/tb_top.sv
module tb_top;
  import pls_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int WORD_BITS      = 32;
  localparam int CW             = $clog2(CAPACITY + 1);
  localparam int IW             = $clog2(CAPACITY);
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // operation codes the block does not implement
  localparam logic [OP_BITS-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0] OP_RSVD_LAST  = 3'd7;

  typedef struct packed {
    logic                 accepted;
    logic [WORD_BITS-1:0] read_word;
    logic [CW-1:0]        entry_count;
    logic                 vacant;
    logic                 full;
  } list_result_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [OP_BITS-1:0]   in_operation     = '0;
  logic [CW-1:0]        in_position      = '0;
  logic [WORD_BITS-1:0] in_element_value = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic                 out_accepted;
  logic [WORD_BITS-1:0] out_read_word;
  logic [CW-1:0]        out_entry_count;
  logic                 out_is_vacant;
  logic                 out_is_full;

  logic [WORD_BITS-1:0] list_words [CAPACITY];
  int                   list_len = 0;
  list_result_t         pending_results [$];
  list_result_t         got_result;
  list_result_t         want_result;
  int                   fail_count   = 0;
  int                   tx_idle_pct  = 0;
  int                   rx_stall_pct = 0;
  int                   hold_req     = 0;
  int                   hold_ack     = 0;
  int                   hold_left    = 0;
  int                   idle_cycles  = 0;
  logic                 growing      = 1'b1;

  positional_list_store_unit #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_read_word    (out_read_word),
    .out_entry_count  (out_entry_count),
    .out_is_vacant    (out_is_vacant),
    .out_is_full      (out_is_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic list_result_t apply_request(input logic [OP_BITS-1:0] op_code,
                                                 input logic [CW-1:0] pos,
                                                 input logic [WORD_BITS-1:0] word);
    list_result_t res;
    int i;
    res = '0;
    case (op_t'(op_code))
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_words[IW'(list_len)] = word;
          list_len++;
          res.accepted = 1'b1;
        end
      end
      OP_INSERT: begin
        if (list_len < CAPACITY && int'(pos) <= list_len) begin
          for (i = list_len; i > int'(pos); i--)
            list_words[IW'(i)] = list_words[IW'(i - 1)];
          list_words[pos[IW-1:0]] = word;
          list_len++;
          res.accepted = 1'b1;
        end
      end
      OP_DELETE_AT: begin
        if (int'(pos) < list_len) begin
          for (i = int'(pos); i + 1 < list_len; i++)
            list_words[IW'(i)] = list_words[IW'(i + 1)];
          list_len--;
          res.accepted = 1'b1;
        end
      end
      OP_DELETE_LAST: begin
        if (list_len > 0) begin
          list_len--;
          res.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (int'(pos) < list_len) begin
          res.read_word = list_words[pos[IW-1:0]];
          res.accepted  = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = list_len[CW-1:0];
    res.vacant      = (list_len == 0);
    res.full        = (list_len == CAPACITY);
    return res;
  endfunction

  function automatic string fmt_result(input list_result_t r);
    return $sformatf("acc=%0d word=%08h count=%0d vacant=%0d full=%0d",
                     r.accepted, r.read_word, r.entry_count, r.vacant, r.full);
  endfunction

  // predict on each request transaction, check each result transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(apply_request(in_operation, in_position, in_element_value));
    if (rst_n && out_valid && !out_stall) begin
      got_result = '{out_accepted, out_read_word, out_entry_count, out_is_vacant, out_is_full};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected transaction: %s", fmt_result(got_result));
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.accepted !== want_result.accepted ||
            got_result.read_word !== want_result.read_word ||
            got_result.entry_count !== want_result.entry_count ||
            got_result.vacant !== want_result.vacant ||
            got_result.full !== want_result.full) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("mismatch: expected %s, actual %s",
                     fmt_result(want_result), fmt_result(got_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OP_BITS-1:0] op_code, input logic [CW-1:0] pos,
                              input logic [WORD_BITS-1:0] word);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op_code;
    in_position      <= pos;
    in_element_value <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_corner_cases();
    logic [OP_BITS-1:0] code;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // empty list refusals
    send_request(OP_READ, '0, '1);
    send_request(OP_DELETE_LAST, '1, '0);
    send_request(OP_DELETE_AT, '0, '0);
    send_request(OP_INSERT, 7'd1, '1);
    // insert at length on empty list, then appends
    send_request(OP_INSERT, '0, 32'hFFFF_FFFF);
    send_request(OP_APPEND, '1, 32'h0000_0000);
    send_request(OP_APPEND, 7'h7F, 32'hA5A5_5A5A);
    send_request(OP_INSERT, 7'd1, 32'h1234_5678);
    send_request(OP_INSERT, 7'd4, 32'h8000_0001);
    for (int p = 0; p <= 5; p++)
      send_request(OP_READ, p[CW-1:0], '0);
    send_request(OP_READ, 7'h7F, '1);
    send_request(OP_DELETE_AT, 7'd5, '0);
    send_request(OP_DELETE_AT, 7'd1, '0);
    send_request(OP_READ, 7'd1, '0);
    send_request(OP_DELETE_AT, 7'h40, '0);
    for (code = OP_RSVD_FIRST; code != OP_APPEND; code++)
      send_request(code, '0, '1);
    send_request(OP_DELETE_LAST, '0, '0);
    send_request(OP_DELETE_AT, '0, '0);
    wait_for_results();
  endtask

  // grows toward full, then shrinks toward empty, so both ends get exercised
  task automatic check_random_traffic(input int count, input int tx_pct, input int rx_pct);
    logic [OP_BITS-1:0]   op_code;
    logic [CW-1:0]        pos;
    logic [WORD_BITS-1:0] word;
    int                   pick;
    int                   n;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (n = 0; n < count; n++) begin
      if (list_len == CAPACITY && $urandom_range(0, 7) == 0)
        growing = 1'b0;
      else if (list_len == 0 && $urandom_range(0, 7) == 0)
        growing = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick >= 95)
        op_code = OP_BITS'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
      else if (growing)
        op_code = pick < 35 ? OP_APPEND : pick < 65 ? OP_INSERT :
                  pick < 75 ? OP_DELETE_AT : pick < 80 ? OP_DELETE_LAST : OP_READ;
      else
        op_code = pick < 10 ? OP_APPEND : pick < 20 ? OP_INSERT :
                  pick < 50 ? OP_DELETE_AT : pick < 70 ? OP_DELETE_LAST : OP_READ;
      if ($urandom_range(0, 99) < 15 || (list_len == 0 && op_code != OP_INSERT))
        pos = CW'($urandom_range(0, 2 ** CW - 1));
      else if (op_code == OP_INSERT)
        pos = CW'($urandom_range(0, list_len));
      else
        pos = CW'($urandom_range(0, list_len - 1));
      pick = $urandom_range(0, 15);
      word = pick == 0 ? '0 : pick == 1 ? '1 : WORD_BITS'($urandom);
      send_request(op_code, pos, word);
    end
    wait_for_results();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic check_stall_pressure();
    hold_req++;
    check_random_traffic(64, 0, 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    check_corner_cases();
    check_random_traffic(330, 0, 0);
    check_random_traffic(330, 68, 0);
    check_stall_pressure();
    check_random_traffic(330, 0, 68);
    check_random_traffic(330, 12, 12);
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
src/pls_pkg.sv
src/pls_cell.sv
src/positional_list_store_unit.sv
dv/tb_top.sv
